// File: design/nc3_pkg.sv
// ----------------------------------------------------------------------------
// nc3_pkg
// Shared types and constants for the 3x3 neighbourhood count unit.
// ----------------------------------------------------------------------------
package nc3_pkg;

   // grid limits
   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 1024;

   // position widths
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int ECOL_W = COL_W + 1;   // holds MAX_COLS itself
   localparam int EROW_W = ROW_W + 1;   // holds MAX_ROWS itself

   // register widths
   localparam int CFG_ROWS_W = 11;
   localparam int CFG_COLS_W = 7;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // result fields
   localparam int CNT_W       = 4;
   localparam int RSP_FIELD_W = ROW_W + COL_W + CNT_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   // line buffer entry: bit 0 = one row back, bit 1 = two rows back
   localparam int LINE_W = 2;

   // input item kinds
   typedef enum logic {
      KIND_CELL  = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   // register indexes
   typedef enum logic {
      REG_NUM_ROWS = 1'b0,
      REG_NUM_COLS = 1'b1
   } reg_index_type;

   // one item handed from the sequencer to the window stage
   typedef struct packed {
      logic             emit;       // item produces a result
      logic             last;       // result closes the frame
      logic [ROW_W-1:0] row;        // counted cell row
      logic [COL_W-1:0] col;        // counted cell column
      logic [COL_W-1:0] addr;       // line buffer column of this item
      logic             top_ok;
      logic             bot_ok;
      logic             left_ok;
      logic             right_ok;
      logic [2:0]       low_bits;   // 0 = this item, 1/2 = one/two items back
   } nc3_item_type;

endpackage

// File: design/neighbourhood_count_3x3_unit.sv
// ----------------------------------------------------------------------------
// neighbourhood_count_3x3_unit
// 3x3 box sum over a binary grid streamed in raster order.
// ----------------------------------------------------------------------------
// Takes one cell beat per clock cycle and gives one count beat per cell, with
// no gaps while both sides keep up. The beat that completes a cell's window
// passes through the line buffer read stage and the result register before
// its count leaves; the line buffer is a single RAM of MAX_COLS two-bit rows
// with one read and one write per cycle, bypassed when consecutive beats hit
// the same column. After the last cell of a frame, send num_cols+1 flush
// beats; the final count carries tlast and the unit is ready for the next
// frame. Writing either register restarts the frame; write only when idle.
// ----------------------------------------------------------------------------
module neighbourhood_count_3x3_unit
   import nc3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // cell beats
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [0] mine
   input  logic                  req_tuser,   // [0] kind

   // count beats
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [9:0] cell_row, [15:10] cell_col,
                                              // [19:16] neighbour_count
   output logic                  rsp_tlast,   // frame_last

   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CFG_ROWS_W-1:0] num_rows_ff, num_rows_in;
   logic [CFG_COLS_W-1:0] num_cols_ff, num_cols_in;

   logic              csr_wr;
   reg_index_type     csr_index;
   logic [EROW_W-1:0] rows_eff;
   logic [ECOL_W-1:0] cols_eff;
   logic              take;
   logic              push;
   nc3_item_type      item;

   // register access
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[2]);

   always_comb begin
      num_rows_in = num_rows_ff;
      num_cols_in = num_cols_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_NUM_ROWS: num_rows_in = csr_pwdata[CFG_ROWS_W-1:0];
            REG_NUM_COLS: num_cols_in = csr_pwdata[CFG_COLS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_NUM_ROWS: csr_prdata = CSR_DATA_W'(num_rows_ff);
         REG_NUM_COLS: csr_prdata = CSR_DATA_W'(num_cols_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff <= CFG_ROWS_W'(6);
         num_cols_ff <= CFG_COLS_W'(6);
      end else begin
         num_rows_ff <= num_rows_in;
         num_cols_ff <= num_cols_in;
      end
   end

   // clamp registers to the supported grid
   always_comb begin
      if (num_rows_ff == '0) begin
         rows_eff = EROW_W'(1);
      end else if (32'(num_rows_ff) > 32'(MAX_ROWS)) begin
         rows_eff = EROW_W'(MAX_ROWS);
      end else begin
         rows_eff = EROW_W'(num_rows_ff);
      end
      if (num_cols_ff == '0) begin
         cols_eff = ECOL_W'(1);
      end else if (32'(num_cols_ff) > 32'(MAX_COLS)) begin
         cols_eff = ECOL_W'(MAX_COLS);
      end else begin
         cols_eff = ECOL_W'(num_cols_ff);
      end
   end

   assign take = req_tvalid && req_tready;

   nc3_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_wr),
      .rows    (rows_eff),
      .cols    (cols_eff),
      .take    (take),
      .kind    (kind_type'(req_tuser)),
      .mine    (req_tdata[0]),
      .push    (push),
      .item    (item)
   );

   nc3_window u_window (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .item        (item),
      .stage_ready (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tlast   (rsp_tlast),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// File: design/nc3_line_ram.sv
// ----------------------------------------------------------------------------
// nc3_line_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module nc3_line_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: design/nc3_seq.sv
// ----------------------------------------------------------------------------
// nc3_seq
// Raster position tracking: input and output positions, result decision,
// border flags and the last two cell bits taken in.
// ----------------------------------------------------------------------------
module nc3_seq
   import nc3_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              restart,
   input  logic [EROW_W-1:0] rows,
   input  logic [ECOL_W-1:0] cols,
   input  logic              take,
   input  kind_type          kind,
   input  logic              mine,
   output logic              push,
   output nc3_item_type      item
);

   logic [EROW_W-1:0] in_row_ff,  in_row_in;
   logic [COL_W-1:0]  in_col_ff,  in_col_in;
   logic [ROW_W-1:0]  out_row_ff, out_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic              emit_ff,    emit_in;
   logic              prev1_ff,   prev1_in;
   logic              prev2_ff,   prev2_in;

   logic              cur;
   logic              ignore;
   logic              emit_now;
   logic              last;
   logic [ECOL_W-1:0] in_col_inc;
   logic [ECOL_W-1:0] out_col_inc;
   logic [EROW_W-1:0] out_row_inc;

   // item decode and border flags
   always_comb begin
      cur         = (kind == KIND_CELL) ? mine : 1'b0;
      ignore      = (kind == KIND_FLUSH) && (in_row_ff == '0) && (in_col_ff == '0)
                    && !emit_ff;
      emit_now    = emit_ff || (in_row_ff >= EROW_W'(2))
                    || ((in_row_ff == EROW_W'(1)) && (in_col_ff != '0));
      in_col_inc  = {1'b0, in_col_ff} + ECOL_W'(1);
      out_col_inc = {1'b0, out_col_ff} + ECOL_W'(1);
      out_row_inc = {1'b0, out_row_ff} + EROW_W'(1);
      last        = ({1'b0, out_row_ff} == (rows - EROW_W'(1)))
                    && (out_col_inc == cols);
      push        = take && !ignore;

      item.emit     = emit_now;
      item.last     = last;
      item.row      = out_row_ff;
      item.col      = out_col_ff;
      item.addr     = in_col_ff;
      item.top_ok   = (out_row_ff != '0);
      item.bot_ok   = (out_row_inc < rows);
      item.left_ok  = (out_col_ff != '0);
      item.right_ok = (out_col_inc < cols);
      item.low_bits = {prev2_ff, prev1_ff, cur};
   end

   // next position
   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      emit_in    = emit_ff;
      prev1_in   = prev1_ff;
      prev2_in   = prev2_ff;
      if (restart) begin
         in_row_in  = '0;
         in_col_in  = '0;
         out_row_in = '0;
         out_col_in = '0;
         emit_in    = 1'b0;
      end else if (push) begin
         prev1_in = cur;
         prev2_in = prev1_ff;
         if (emit_now && last) begin
            in_row_in  = '0;
            in_col_in  = '0;
            out_row_in = '0;
            out_col_in = '0;
            emit_in    = 1'b0;
         end else begin
            if (in_col_inc >= cols) begin
               in_col_in = '0;
               in_row_in = in_row_ff + EROW_W'(1);
            end else begin
               in_col_in = in_col_inc[COL_W-1:0];
            end
            if (emit_now) begin
               emit_in = 1'b1;
               if (out_col_inc >= cols) begin
                  out_col_in = '0;
                  out_row_in = out_row_inc[ROW_W-1:0];
               end else begin
                  out_col_in = out_col_inc[COL_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff  <= '0;
         in_col_ff  <= '0;
         out_row_ff <= '0;
         out_col_ff <= '0;
         emit_ff    <= 1'b0;
         prev1_ff   <= 1'b0;
         prev2_ff   <= 1'b0;
      end else begin
         in_row_ff  <= in_row_in;
         in_col_ff  <= in_col_in;
         out_row_ff <= out_row_in;
         out_col_ff <= out_col_in;
         emit_ff    <= emit_in;
         prev1_ff   <= prev1_in;
         prev2_ff   <= prev2_in;
      end
   end

endmodule

// File: design/nc3_window.sv
// ----------------------------------------------------------------------------
// nc3_window
// Line buffer read-modify-write, window taps, 3x3 count and result register.
// ----------------------------------------------------------------------------
module nc3_window
   import nc3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  nc3_item_type          item,
   output logic                  stage_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tlast,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stage 1 holds the item whose line buffer read is in flight
   logic               s1_valid_ff, s1_valid_in;
   nc3_item_type       s1_item_ff;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [LINE_W-1:0]  fwd_data_ff;

   // delayed buffer taps: one and two items back
   logic               mid1_ff, mid2_ff, top1_ff, top2_ff;

   // result register
   logic               out_valid_ff, out_valid_in;
   logic [ROW_W-1:0]   out_row_ff;
   logic [COL_W-1:0]   out_col_ff;
   logic [CNT_W-1:0]   out_cnt_ff;
   logic               out_last_ff;

   logic               s1_adv;
   logic               s1_fire;
   logic [LINE_W-1:0]  ram_q;
   logic [LINE_W-1:0]  line_q;
   logic [LINE_W-1:0]  wr_data;
   logic [8:0]         taps;
   logic [CNT_W-1:0]   count;

   // handshake between stages
   assign s1_adv      = !out_valid_ff || rsp_tready;
   assign s1_fire     = s1_valid_ff && s1_adv;
   assign stage_ready = !s1_valid_ff || s1_adv;

   // line buffer read data, bypassed when the item ahead wrote the same column
   assign line_q  = fwd_hit_ff ? fwd_data_ff : ram_q;
   assign wr_data = {line_q[0], s1_item_ff.low_bits[0]};
   assign fwd_hit_in = push && s1_fire && (s1_item_ff.addr == item.addr);

   nc3_line_ram #(
      .DEPTH (MAX_COLS),
      .WIDTH (LINE_W)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_item_ff.addr),
      .wr_data (wr_data),
      .rd_en   (push),
      .rd_addr (item.addr),
      .rd_data (ram_q)
   );

   // window taps, out-of-grid cells masked
   always_comb begin
      taps[0] = top2_ff & s1_item_ff.top_ok & s1_item_ff.left_ok;
      taps[1] = top1_ff & s1_item_ff.top_ok;
      taps[2] = line_q[1] & s1_item_ff.top_ok & s1_item_ff.right_ok;
      taps[3] = mid2_ff & s1_item_ff.left_ok;
      taps[4] = mid1_ff;
      taps[5] = line_q[0] & s1_item_ff.right_ok;
      taps[6] = s1_item_ff.low_bits[2] & s1_item_ff.bot_ok & s1_item_ff.left_ok;
      taps[7] = s1_item_ff.low_bits[1] & s1_item_ff.bot_ok;
      taps[8] = s1_item_ff.low_bits[0] & s1_item_ff.bot_ok & s1_item_ff.right_ok;
      count = '0;
      for (int i = 0; i < 9; i++) begin
         count = count + CNT_W'(taps[i]);
      end
   end

   // stage valid and result valid
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (push) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_fire && s1_item_ff.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= push ? fwd_hit_in : fwd_hit_ff;
         out_valid_ff <= out_valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (push) begin
         s1_item_ff  <= item;
         fwd_data_ff <= wr_data;
      end
      if (s1_fire) begin
         mid1_ff <= line_q[0];
         mid2_ff <= mid1_ff;
         top1_ff <= line_q[1];
         top2_ff <= top1_ff;
      end
      if (s1_fire && s1_item_ff.emit) begin
         out_row_ff  <= s1_item_ff.row;
         out_col_ff  <= s1_item_ff.col;
         out_cnt_ff  <= count;
         out_last_ff <= s1_item_ff.last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELD_W)'(0), out_cnt_ff, out_col_ff, out_row_ff};

   // new item only when stage 1 is empty or moving on
   a_stage_free: assert property (@(posedge clock) disable iff (reset)
      push |-> (!s1_valid_ff || s1_fire))
      else $error("item pushed into an occupied, stalled stage");

   // bypass set exactly when the entering item reads the column being written
   a_fwd_source: assert property (@(posedge clock) disable iff (reset)
      push |=> (fwd_hit_ff == $past(s1_fire && (s1_item_ff.addr == item.addr))))
      else $error("line buffer bypass without matching write");

   // result register never overwritten while its beat is pending
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_item_ff.emit) |-> (!out_valid_ff || rsp_tready))
      else $error("pending result overwritten");

endmodule

// File: bench/neighbourhood_count_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbourhood_count_checker
// Watches the cell, count and register channels of the 3x3 count unit.
// ----------------------------------------------------------------------------
// Keeps its own copy of the grid size registers and of the raster position,
// rebuilds the window sum for every accepted cell beat and queues the count
// it should produce. Every accepted count beat is compared field by field with
// the oldest queued count. Failures, queued counts and checked counts are
// handed to the bench top.
// ----------------------------------------------------------------------------
module neighbourhood_count_checker
   import nc3_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tuser,

   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tlast,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,

   output int                    fail_count,
   output int                    pending,
   output int                    counts_checked
);

   // cells remembered behind the current beat: two rows plus two
   localparam int PAST_N = 2 * MAX_COLS + 2;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [CNT_W-1:0] count;
      logic             last;
   } cell_count_type;

   logic [CFG_ROWS_W-1:0] rows_reg;
   logic [CFG_COLS_W-1:0] cols_reg;
   logic [PAST_N-1:0]     past_cells;   // bit 0 = previous beat
   int                    in_row;
   int                    in_col;
   int                    out_row;
   int                    out_col;
   bit                    counting;
   cell_count_type        expected_counts[$];
   int                    errors = 0;
   int                    matched = 0;

   function automatic int clamp_dim(input int raw, input int top);
      return (raw == 0) ? 1 : ((raw > top) ? top : raw);
   endfunction

   task automatic restart_frame();
      in_row   = 0;
      in_col   = 0;
      out_row  = 0;
      out_col  = 0;
      counting = 1'b0;
   endtask

   // one cell beat: window sum for the pending cell, then raster advance
   task automatic take_cell(input kind_type kind, input logic mine);
      int             rows;
      int             cols;
      int             dr;
      int             dc;
      int             r;
      int             c;
      int             back;
      logic           cur;
      logic           last;
      logic [CNT_W-1:0] sum;
      cell_count_type beat;
      rows = clamp_dim(int'(rows_reg), MAX_ROWS);
      cols = clamp_dim(int'(cols_reg), MAX_COLS);
      cur  = (kind == KIND_CELL) ? mine : 1'b0;
      last = 1'b0;
      // a flush beat before any cell of the frame is dropped
      if (!(kind == KIND_FLUSH && in_row == 0 && in_col == 0 && !counting)) begin
         if (in_row * cols + in_col >= cols + 1)
            counting = 1'b1;
         if (counting) begin
            sum = '0;
            for (dr = -1; dr <= 1; dr++) begin
               for (dc = -1; dc <= 1; dc++) begin
                  r = out_row + dr;
                  c = out_col + dc;
                  if (r >= 0 && c >= 0 && r < rows && c < cols) begin
                     back = cols + 1 - dr * cols - dc;
                     if (back == 0)
                        sum = sum + CNT_W'(cur);
                     else if (back <= PAST_N)
                        sum = sum + CNT_W'(past_cells[back-1]);
                  end
               end
            end
            last       = (out_row == rows - 1 && out_col == cols - 1);
            beat.row   = ROW_W'(out_row);
            beat.col   = COL_W'(out_col);
            beat.count = sum;
            beat.last  = last;
            expected_counts.push_back(beat);
         end
         past_cells = {past_cells[PAST_N-2:0], cur};
         if (last) begin
            restart_frame();
         end else begin
            if (counting) begin
               out_col++;
               if (out_col >= cols) begin
                  out_col = 0;
                  out_row++;
               end
            end
            in_col++;
            if (in_col >= cols) begin
               in_col = 0;
               in_row++;
            end
         end
      end
   endtask

   function automatic void report_field(input string name, input int want, input int got);
      errors++;
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
   endfunction

   task automatic check_count();
      cell_count_type want;
      cell_count_type got;
      got.row   = rsp_tdata[ROW_W-1:0];
      got.col   = rsp_tdata[ROW_W +: COL_W];
      got.count = rsp_tdata[ROW_W+COL_W +: CNT_W];
      got.last  = rsp_tlast;
      if (expected_counts.size() == 0) begin
         errors++;
         $display("%0t ns: count beat with none pending: expected none, actual %0d,%0d = %0d last %0b",
                  $time, got.row, got.col, got.count, got.last);
      end else begin
         want = expected_counts.pop_front();
         matched++;
         if (got.row != want.row)
            report_field("cell_row", want.row, got.row);
         if (got.col != want.col)
            report_field("cell_col", want.col, got.col);
         if (got.count != want.count)
            report_field("neighbour_count", want.count, got.count);
         if (got.last != want.last)
            report_field("frame_last", want.last, got.last);
      end
   endtask

   // sample all channels at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         rows_reg   = CFG_ROWS_W'(6);
         cols_reg   = CFG_COLS_W'(6);
         past_cells = '0;
         restart_frame();
         expected_counts.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if ((csr_paddr >> 2) == int'(REG_NUM_ROWS)) begin
               rows_reg = csr_pwdata[CFG_ROWS_W-1:0];
               restart_frame();
            end else if ((csr_paddr >> 2) == int'(REG_NUM_COLS)) begin
               cols_reg = csr_pwdata[CFG_COLS_W-1:0];
               restart_frame();
            end
         end
         if (req_tvalid && req_tready)
            take_cell(kind_type'(req_tuser), req_tdata[0]);
         if (rsp_tvalid && rsp_tready)
            check_count();
      end
      fail_count     <= errors;
      pending        <= expected_counts.size();
      counts_checked <= matched;
   end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the 3x3 neighbourhood count unit.
// ----------------------------------------------------------------------------
// Streams binary frames through the unit under a range of grid sizes,
// including clamped register values and the tallest and widest grids, with
// surplus, early and late flush beats mixed in. Both channels idle at random.
// A separate checker predicts and compares every count beat.
// ----------------------------------------------------------------------------
module tb
   import nc3_pkg::*;
();

   logic                  clock;
   logic                  reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;    // [0] mine
   logic                  req_tuser = 1'b0;  // [0] kind

   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [9:0] cell_row, [15:10] cell_col,
                                             // [19:16] neighbour_count
   logic                  rsp_tlast;         // frame_last

   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int                    fail_count;
   int                    pending;
   int                    counts_checked;

   bit                    calm = 1'b0;      // no input gaps for this frame
   bit                    rsp_calm = 1'b0;  // no output stalls for this frame
   int                    rsp_hold = 0;
   int                    rows_now = 6;
   int                    cols_now = 6;
   int                    beats_sent = 0;
   int                    frames_run = 0;
   int                    settings_used = 1;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   neighbourhood_count_3x3_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   neighbourhood_count_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .fail_count     (fail_count),
      .pending        (pending),
      .counts_checked (counts_checked)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic int clamp_dim(input int raw, input int top);
      return (raw == 0) ? 1 : ((raw > top) ? top : raw);
   endfunction

   // count side back-pressure
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = rsp_calm ? 0 : pick_gap();
      end
   end

   // one cell beat, held until taken, then an optional gap
   task automatic send_beat(input kind_type kind, input logic mine);
      int gap;
      gap = calm ? 0 : pick_gap();
      req_tuser  <= kind;
      req_tdata  <= {7'b0, mine};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait for all counts plus the pipeline depth of dropped beats
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input int val);
      logic [CSR_DATA_W-1:0] keep;
      logic [CSR_DATA_W-1:0] junk;
      keep = (idx == REG_NUM_ROWS) ? CSR_DATA_W'(32'h7FF) : CSR_DATA_W'(32'h7F);
      junk = ($urandom_range(0, 3) == 0) ? ($urandom & ~keep) : '0;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(idx));
      csr_pwdata  <= (CSR_DATA_W'(val) & keep) | junk;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // a negative value leaves that register alone
   task automatic set_grid(input int rows_val, input int cols_val);
      drain();
      if (rows_val >= 0) begin
         csr_write(REG_NUM_ROWS, rows_val);
         rows_now = rows_val;
      end
      if (cols_val >= 0) begin
         csr_write(REG_NUM_COLS, cols_val);
         cols_now = cols_val;
      end
      settings_used++;
   endtask

   // one frame of random cells, some frames with broken flush patterns
   task automatic run_frame();
      int  rows;
      int  cols;
      int  density;
      int  i;
      int  extra;
      bit  noisy;
      rows    = clamp_dim(rows_now, MAX_ROWS);
      cols    = clamp_dim(cols_now, MAX_COLS);
      density = $urandom_range(0, 4) * 25;
      noisy   = ($urandom_range(0, 3) == 0);
      calm    = ($urandom_range(0, 3) == 0);
      rsp_calm <= ($urandom_range(0, 3) == 0);
      // surplus flush beats at the frame start are dropped
      extra   = noisy ? $urandom_range(1, 3) : 0;
      repeat (extra) send_beat(KIND_FLUSH, 1'($urandom_range(0, 1)));
      for (i = 0; i < rows * cols; i++) begin
         if (noisy && i > 0 && $urandom_range(0, 19) == 0)
            send_beat(KIND_FLUSH, 1'($urandom_range(0, 1)));
         else
            send_beat(KIND_CELL, 1'($urandom_range(0, 99) < density));
      end
      for (i = 0; i <= cols; i++) begin
         if (noisy && $urandom_range(0, 4) == 0)
            send_beat(KIND_CELL, 1'($urandom_range(0, 1)));
         else
            send_beat(KIND_FLUSH, 1'($urandom_range(0, 1)));
      end
      beats_sent += extra + rows * cols + cols + 1;
      frames_run++;
   endtask

   initial begin
      int start_beats;
      int pick;
      int r;
      int c;
      int which;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset sizes first
      run_frame();

      // directed: single cell grid, surplus and late flushes
      set_grid(1, 1);
      calm = 1'b0;
      send_beat(KIND_FLUSH, 1'b1);
      send_beat(KIND_CELL, 1'b1);
      send_beat(KIND_FLUSH, 1'b0);
      send_beat(KIND_FLUSH, 1'b1);
      send_beat(KIND_CELL, 1'b0);
      send_beat(KIND_CELL, 1'b1);
      send_beat(KIND_FLUSH, 1'b0);
      // full 2x2 grid, every window holds four
      set_grid(2, 2);
      repeat (4) send_beat(KIND_CELL, 1'b1);
      repeat (3) send_beat(KIND_FLUSH, 1'b0);
      // early flush inside the frame counts as an empty cell
      set_grid(2, 3);
      send_beat(KIND_CELL, 1'b1);
      send_beat(KIND_FLUSH, 1'b1);
      send_beat(KIND_CELL, 1'b1);
      send_beat(KIND_CELL, 1'b1);
      send_beat(KIND_CELL, 1'b0);
      send_beat(KIND_CELL, 1'b1);
      repeat (4) send_beat(KIND_FLUSH, 1'b0);
      beats_sent += 24;

      // random sizes, mostly small
      start_beats = beats_sent;
      while (beats_sent - start_beats < 300) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            r = $urandom_range(1, 6);
            c = $urandom_range(1, 10);
         end else if (pick < 75) begin
            r = $urandom_range(1, 2);
            c = $urandom_range(0, 1) ? MAX_COLS : $urandom_range(MAX_COLS + 1, 127);
         end else if (pick < 85) begin
            r = $urandom_range(0, 3);
            c = $urandom_range(0, 4);
         end else begin
            r = $urandom_range(7, 20);
            c = $urandom_range(1, 3);
         end
         which = $urandom_range(0, 3);
         if (which == 0)
            c = -1;
         else if (which == 1)
            r = -1;
         set_grid(r, c);
         repeat ($urandom_range(1, 3)) run_frame();
      end

      // tallest and widest grids through clamped register values
      set_grid(2047, 0);
      run_frame();
      set_grid(0, 127);
      run_frame();

      drain();
      $display("Ran %0d cell beats in %0d random frames over %0d grid settings", beats_sent,
               frames_run, settings_used);
      $display("%0d counts compared", counts_checked);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// File: neighbourhood_count_3x3_unit.f
design/nc3_pkg.sv
design/nc3_line_ram.sv
design/nc3_seq.sv
design/nc3_window.sv
design/neighbourhood_count_3x3_unit.sv
bench/neighbourhood_count_checker.sv
bench/tb.sv
